>>> hw/rtl/cbea_pkg.sv
// Shared types, constants and sizes of the critical-band energy accumulator.
package cbea_pkg;

   // Storage sizes
   localparam int NUM_BANDS    = 32;
   localparam int NUM_BINS     = 512;
   localparam int WEIGHT_DEPTH = 1024;

   localparam int BAND_W  = $clog2(NUM_BANDS);
   localparam int BAND_CW = $clog2(NUM_BANDS + 1);
   localparam int BIN_W   = $clog2(NUM_BINS);
   localparam int WADDR_W = $clog2(WEIGHT_DEPTH);

   // Field widths
   localparam int CMD_W      = 2;
   localparam int INDEX_W    = 10;
   localparam int WEIGHT_W   = 16;
   localparam int RANGE_W    = 9;
   localparam int BASE_W     = 10;
   localparam int POWER_W    = 32;
   localparam int BANDNUM_W  = 5;
   localparam int ENERGY_W   = 42;
   localparam int ACC_W      = 57;
   localparam int PROD_W     = POWER_W + WEIGHT_W;
   localparam int ENERGY_SHIFT = 15;

   // Weight address arithmetic width: covers base plus bin offset
   localparam int SUM_W = ((BIN_W > BASE_W) ? BIN_W : BASE_W) + 2;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;
   localparam int BAND_COUNT_W = 6;
   localparam int FIRST_BAND_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_COUNT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_BAND = 4'd1;
   localparam logic [BAND_COUNT_W-1:0] BAND_COUNT_RESET = 6'd32;
   localparam logic [FIRST_BAND_W-1:0] FIRST_BAND_RESET = 3'd1;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RANGE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_BIN    = 2'd2;

   typedef enum logic [1:0] {
      OP_WEIGHT,
      OP_RANGE,
      OP_BIN,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [INDEX_W-1:0]  table_index;
      logic [WEIGHT_W-1:0] weight_value;
      logic [RANGE_W-1:0]  range_first_bin;
      logic [RANGE_W-1:0]  range_last_bin;
      logic [BASE_W-1:0]   range_weight_base;
      logic [POWER_W-1:0]  bin_power;
      logic                final_bin;
   } req_type;

   typedef struct packed {
      logic [BANDNUM_W-1:0] band_number;
      logic [ENERGY_W-1:0]  band_energy;
      logic                 final_band;
   } rsp_type;

   typedef struct packed {
      op_type  op;
      req_type item;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_out_type;

   typedef struct packed {
      logic               active;
      logic [BAND_CW-1:0] lo;
      logic [BAND_CW-1:0] hi;
   } span_type;

endpackage

>>> hw/rtl/cbea_front.sv
// Front end: takes requests, classifies the command and queues them for the back end.
module cbea_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  cbea_pkg::req_type        req_data,
   input  logic                     q_pop,
   output cbea_pkg::queue_out_type  q_out
);
   import cbea_pkg::*;

   queue_entry_type    queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               accept;
   logic               push;
   logic               pop;
   op_type             op;

   always_comb begin
      case (req_data.cmd)
         CMD_WEIGHT: op = OP_WEIGHT;
         CMD_RANGE:  op = OP_RANGE;
         CMD_BIN:    op = OP_BIN;
         default:    op = OP_NONE;
      endcase
   end

   assign busy   = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept = start && !busy;
   // Drop unknown commands here: they never reach the back end
   assign push   = accept && (op != OP_NONE);
   assign pop    = q_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{op: op, item: req_data};
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.entry = queue_ff[rd_ptr_ff];

endmodule

>>> hw/rtl/cbea_back.sv
// Back end: table writes, per-band multiply-accumulate over each bin, and band reports.
module cbea_back (
   input  logic                     clock,
   input  logic                     reset,
   input  cbea_pkg::queue_out_type  q_out,
   output logic                     q_pop,
   input  cbea_pkg::span_type       span,
   output logic                     rsp_valid,
   output cbea_pkg::rsp_type        rsp_data
);
   import cbea_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ACCUM  = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_REPORT = 5'b10000
   } back_state_type;

   localparam logic [ACC_W:0] ACC_MAX = {1'b0, {ACC_W{1'b1}}};

   back_state_type       state_ff, state_in;
   logic [BAND_CW-1:0]   band_ff, band_in;
   logic [BIN_W-1:0]     pos_ff, pos_in;
   logic [POWER_W-1:0]   power_ff;
   logic                 final_ff;

   logic [WEIGHT_W-1:0]  weight_mem [WEIGHT_DEPTH];
   logic [RANGE_W-1:0]   low_bin_ff  [NUM_BANDS];
   logic [RANGE_W-1:0]   high_bin_ff [NUM_BANDS];
   logic [BASE_W-1:0]    base_ff     [NUM_BANDS];
   logic [ACC_W-1:0]     acc_ff      [NUM_BANDS];

   // Pipeline: issue -> weight read (A) -> product (B) -> accumulate
   logic                 a_vld_ff, a_ok_ff;
   logic [BAND_W-1:0]    a_band_ff;
   logic [WEIGHT_W-1:0]  wdata_ff;
   logic                 b_vld_ff, b_ok_ff;
   logic [BAND_W-1:0]    b_band_ff;
   logic [PROD_W-1:0]    prod_ff;

   queue_entry_type      head;
   logic [31:0]          idx_x;
   logic                 weight_we;
   logic                 range_we;
   logic [BAND_CW-1:0]   band_next;
   logic                 band_last;
   logic [BAND_W-1:0]    band_sel;
   logic [SUM_W-1:0]     pos_x, low_x, high_x, addr_sum;
   logic                 hit;
   logic [WADDR_W-1:0]   raddr;
   logic [BAND_W-1:0]    acc_raddr;
   logic [ACC_W-1:0]     acc_rd;
   logic [ACC_W:0]       acc_sum;
   logic [ACC_W-1:0]     acc_new;
   logic                 acc_we;
   logic                 clear;
   logic                 issue;
   logic [BIN_W:0]       pos_inc;

   assign head      = q_out.entry;
   assign q_pop     = (state_ff == ST_IDLE) && q_out.valid;
   assign idx_x     = 32'(head.item.table_index);
   assign weight_we = q_pop && (head.op == OP_WEIGHT) && (idx_x < WEIGHT_DEPTH);
   assign range_we  = q_pop && (head.op == OP_RANGE) && (idx_x < NUM_BANDS);

   assign band_next = band_ff + 1'b1;
   assign band_last = (band_next >= span.hi);
   assign band_sel  = BAND_W'(band_ff);
   assign issue     = (state_ff == ST_ACCUM);

   // Band coverage and weight address for the band being issued
   always_comb begin
      pos_x    = SUM_W'(pos_ff);
      low_x    = SUM_W'(low_bin_ff[band_sel]);
      high_x   = SUM_W'(high_bin_ff[band_sel]);
      addr_sum = SUM_W'(base_ff[band_sel]) + pos_x - low_x;
      hit      = (pos_x >= low_x) && (pos_x <= high_x) &&
                 (addr_sum < SUM_W'(WEIGHT_DEPTH));
      raddr    = WADDR_W'(addr_sum);
   end

   assign pos_inc = {1'b0, pos_ff} + 1'b1;

   always_comb begin
      state_in = state_ff;
      band_in  = band_ff;
      pos_in   = pos_ff;
      clear    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop && (head.op == OP_BIN)) begin
               band_in  = span.lo;
               state_in = span.active ? ST_ACCUM : ST_FINISH;
            end
         end
         ST_ACCUM: begin
            band_in = band_next;
            if (band_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!a_vld_ff && !b_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!final_ff) begin
               pos_in   = (pos_inc >= (BIN_W + 1)'(NUM_BINS)) ? '0 : BIN_W'(pos_inc);
               state_in = ST_IDLE;
            end else if (span.active) begin
               band_in  = span.lo;
               state_in = ST_REPORT;
            end else begin
               clear    = 1'b1;
               pos_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_REPORT: begin
            band_in = band_next;
            if (band_last) begin
               clear    = 1'b1;
               pos_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         band_ff  <= '0;
         pos_ff   <= '0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         pos_ff   <= pos_in;
         a_vld_ff <= issue;
         b_vld_ff <= a_vld_ff;
      end
   end

   // Latch the bin under work
   always_ff @(posedge clock) begin
      if (q_pop && (head.op == OP_BIN)) begin
         power_ff <= head.item.bin_power;
         final_ff <= head.item.final_bin;
      end
   end

   always_ff @(posedge clock) begin
      if (weight_we) begin
         weight_mem[WADDR_W'(idx_x)] <= head.item.weight_value;
      end
      wdata_ff <= weight_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (range_we) begin
         low_bin_ff[BAND_W'(idx_x)]  <= head.item.range_first_bin;
         high_bin_ff[BAND_W'(idx_x)] <= head.item.range_last_bin;
         base_ff[BAND_W'(idx_x)]     <= head.item.range_weight_base;
      end
   end

   always_ff @(posedge clock) begin
      a_ok_ff   <= hit;
      a_band_ff <= band_sel;
      b_ok_ff   <= a_ok_ff;
      b_band_ff <= a_band_ff;
      prod_ff   <= power_ff * wdata_ff;
   end

   // One accumulator read address: the accumulate stage, or the band being reported
   assign acc_raddr = (state_ff == ST_REPORT) ? band_sel : b_band_ff;
   assign acc_rd    = acc_ff[acc_raddr];
   assign acc_sum   = {1'b0, acc_rd} + (ACC_W + 1)'(prod_ff);
   // Saturate at the top of the accumulator
   assign acc_new   = (acc_sum > ACC_MAX) ? ACC_MAX[ACC_W-1:0] : acc_sum[ACC_W-1:0];
   assign acc_we    = b_vld_ff && b_ok_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < NUM_BANDS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (acc_we) begin
         acc_ff[b_band_ff] <= acc_new;
      end
   end

   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_REPORT);
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.band_number <= BANDNUM_W'(band_ff);
      rsp_data_ff.band_energy <= ENERGY_W'(acc_rd >> ENERGY_SHIFT);
      rsp_data_ff.final_band  <= band_last;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/critical_band_energy_accumulator.sv
// Top level: configuration registers, active band span, front end and back end.
// A weight or band range write is done when the back end takes it from the queue; a bin
// is worked over its A active bands one after another by the single shared multiply-accumulate.
// A final bin adds A band reports, one result a cycle, the first registered out of the report
// state after the drain and finish steps. The two-entry request queue keeps busy low while it has room.
// Reset (synchronous): clears queue, accumulators and bin counter; band_count 32, first_band 1.
// Results are strobes for one cycle; the receiver cannot stall them.
module critical_band_energy_accumulator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  cbea_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output cbea_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cbea_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cbea_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import cbea_pkg::*;

   logic [BAND_COUNT_W-1:0] band_count_ff;
   logic [FIRST_BAND_W-1:0] first_band_ff;
   logic                    csr_we;
   queue_out_type           q_out;
   logic                    q_pop;
   span_type                span;
   int                      bc_i;
   int                      fb_i;
   int                      hi_i;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_count_ff <= BAND_COUNT_RESET;
         first_band_ff <= FIRST_BAND_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BAND_COUNT: band_count_ff <= BAND_COUNT_W'(csr_wdata);
            CSR_FIRST_BAND: first_band_ff <= FIRST_BAND_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // Active bands run from first_band up to the clamped count less first_band
   always_comb begin
      bc_i = (int'(band_count_ff) > NUM_BANDS) ? NUM_BANDS : int'(band_count_ff);
      fb_i = int'(first_band_ff);
      hi_i = (bc_i > fb_i) ? bc_i - fb_i : 0;
      span.active = (fb_i < hi_i);
      span.lo     = BAND_CW'(fb_i);
      span.hi     = BAND_CW'(hi_i);
   end

   cbea_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_pop    (q_pop),
      .q_out    (q_out)
   );

   cbea_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .q_pop     (q_pop),
      .span      (span),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
